[hdl/ple_pkg.sv]
// Shared types, constants and a helper function for the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_POP_BACK   = 3'd1,
    ACT_PUSH_FRONT = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_RD_FRONT   = 3'd4,
    ACT_RD_BACK    = 3'd5,
    ACT_RD_INDEX   = 3'd6,
    ACT_INSERT     = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] item_value;
    logic [6:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    status_t            status;
    logic [6:0]         entry_count;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_RD_FRONT,
    OP_RD_BACK,
    OP_RD_INDEX,
    OP_SH_INIT,
    OP_SH_RD,
    OP_SH_WR,
    OP_INS_WR
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SH_RD,
    S_SH_WR,
    S_INSERT
  } ctrl_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_t  op;
    logic    emit;
    status_t status;
    logic    use_rdata;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    empty;
    logic    full;
    logic    pos_zero;
    logic    pos_lt_cnt;
    logic    sh_last;
  } dp_stat_t;

  // Maps a logical list index onto a physical slot of the circular store.
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
                                              input logic [CW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + (AW+1)'(idx);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/ple_ctrl.sv]
// Controller state machine that sequences each list action through the datapath.
`default_nettype none

module ple_ctrl
  import ple_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NONE;
    cmd.emit      = 1'b0;
    cmd.status    = STAT_OK;
    cmd.use_rdata = 1'b0;
    busy          = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_IDLE;
        cmd.emit  = 1'b1;
        unique case (stat.action)
          ACT_PUSH_BACK: begin
            if (stat.full) cmd.status = STAT_FULL;
            else           cmd.op     = OP_PUSH_BACK;
          end
          ACT_PUSH_FRONT: begin
            if (stat.full) cmd.status = STAT_FULL;
            else           cmd.op     = OP_PUSH_FRONT;
          end
          ACT_POP_BACK: begin
            if (stat.empty) cmd.status = STAT_MISSING;
            else            cmd.op     = OP_POP_BACK;
          end
          ACT_POP_FRONT: begin
            if (stat.empty) cmd.status = STAT_MISSING;
            else            cmd.op     = OP_POP_FRONT;
          end
          ACT_RD_FRONT, ACT_RD_BACK: begin
            if (stat.empty) begin
              cmd.status = STAT_MISSING;
            end else begin
              cmd.op    = (stat.action == ACT_RD_FRONT) ? OP_RD_FRONT : OP_RD_BACK;
              cmd.emit  = 1'b0;
              state_nxt = S_READ;
            end
          end
          ACT_RD_INDEX: begin
            if (!stat.pos_lt_cnt) begin
              cmd.status = STAT_MISSING;
            end else begin
              cmd.op    = OP_RD_INDEX;
              cmd.emit  = 1'b0;
              state_nxt = S_READ;
            end
          end
          ACT_INSERT: begin
            if (stat.full) begin
              cmd.status = STAT_FULL;
            end else if (stat.empty || stat.pos_zero) begin
              cmd.op = OP_PUSH_FRONT;
            end else if (!stat.pos_lt_cnt) begin
              cmd.op = OP_PUSH_BACK;
            end else begin
              cmd.op    = OP_SH_INIT;
              cmd.emit  = 1'b0;
              state_nxt = S_SH_RD;
            end
          end
          default: begin
            cmd.status = STAT_MISSING;
          end
        endcase
      end

      S_READ: begin
        cmd.emit      = 1'b1;
        cmd.use_rdata = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_SH_RD: begin
        cmd.op    = OP_SH_RD;
        state_nxt = S_SH_WR;
      end

      S_SH_WR: begin
        cmd.op    = OP_SH_WR;
        state_nxt = stat.sh_last ? S_INSERT : S_SH_RD;
      end

      S_INSERT: begin
        cmd.op    = OP_INS_WR;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/ple_dpath.sv]
// Datapath: circular entry store, head and count registers, shift index and result register.
`default_nettype none

module ple_dpath
  import ple_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      stat,
  output logic          out_strobe,
  output out_item_t     out_item
);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   mem_q_r;

  in_item_t      item_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic          out_strobe_r;
  out_item_t     out_item_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] sh_dec;

  assign pos_c  = CW'(item_r.position);
  assign sh_dec = sh_r - CW'(1);

  assign stat.action     = item_r.action;
  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r >= CW'(DEPTH));
  assign stat.pos_zero   = (item_r.position == '0);
  assign stat.pos_lt_cnt = ({{CW{1'b0}}, item_r.position} < {7'd0, count_r});
  assign stat.sh_last    = (sh_dec == pos_c);

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    sh_nxt    = sh_r;
    wr_en     = 1'b0;
    wr_addr   = phys_addr(head_r, count_r);
    wr_data   = item_r.item_value;
    rd_addr   = phys_addr(head_r, '0);

    case (cmd.op)
      OP_PUSH_BACK: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
      end
      OP_PUSH_FRONT: begin
        head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
        wr_en     = 1'b1;
        wr_addr   = head_nxt;
        count_nxt = count_r + CW'(1);
      end
      OP_POP_BACK: begin
        count_nxt = count_r - CW'(1);
      end
      OP_POP_FRONT: begin
        head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
        count_nxt = count_r - CW'(1);
      end
      OP_RD_FRONT: begin
        rd_addr = phys_addr(head_r, '0);
      end
      OP_RD_BACK: begin
        rd_addr = phys_addr(head_r, count_r - CW'(1));
      end
      OP_RD_INDEX: begin
        rd_addr = phys_addr(head_r, pos_c);
      end
      OP_SH_INIT: begin
        sh_nxt = count_r;
      end
      OP_SH_RD: begin
        rd_addr = phys_addr(head_r, sh_dec);
      end
      OP_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = phys_addr(head_r, sh_r);
        wr_data = mem_q_r;
        sh_nxt  = sh_dec;
      end
      OP_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = phys_addr(head_r, pos_c);
        count_nxt = count_r + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      item_r <= in_item;
    end
    sh_r <= sh_nxt;
    if (cmd.emit) begin
      out_item_r.read_value  <= cmd.use_rdata ? mem_q_r : 32'sd0;
      out_item_r.status      <= cmd.status;
      out_item_r.entry_count <= 7'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      head_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      out_strobe_r <= cmd.emit;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

[hdl/positional_list_engine.sv]
// Top level of the positional list engine: controller, datapath and checks.
// An accepted start loads the item and enters decode; pushes, pops and refused actions
// emit their result there, reads go through the read state, and an insert in the middle
// of the list runs one read and one write of the entry store per shift before its write.
// One item is in work at a time; busy is low again in the cycle the result is shown.
// Synchronous active-low reset empties the list; store contents stay undefined until written.
`default_nettype none

module positional_list_engine
  import ple_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_strobe,
  output out_item_t     out_item
);

  // The list is held in a circular store addressed from a head pointer, so pushes and
  // pops at either end are single writes or pointer moves. Only an insert strictly
  // inside the list moves entries, one slot per read and write pair, from the back.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  ple_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The result register sits in the datapath, so a result transfer overlaps the
  // acceptance of the next item.
  ple_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // A result is only produced for an item that was being worked on.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result transfer without an item in work");

  // An accepted item always occupies the engine for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the engine busy");

  // The reported count never exceeds the list capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.entry_count <= 7'(DEPTH)))
    else $error("entry count beyond capacity");

  // A refusal for a full list only happens when the list really is full.
  a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status == STAT_FULL)) |->
      (out_item.entry_count == 7'(DEPTH)))
    else $error("full status with a list that is not full");

endmodule

`default_nettype wire

[tb/sv/tb_positional_list_engine.sv]
// Self-checking testbench for the positional list engine: stimulus, prediction and result checks.
`timescale 1ns / 1ps

module tb_positional_list_engine
  import ple_pkg::*;
;

  // The slowest item is an insert just behind the front of a nearly full list. It takes
  // one read and one write of the store for each entry that moves, plus the decode and
  // insert steps.
  localparam int WORST_LATENCY = 2 * DEPTH + 8;
  localparam int ITEM_TOTAL    = 1050;
  localparam int PHASE_LEN     = 100;
  // The limit takes every item at its worst latency plus an idle gap, several times over.
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_MAX    = 10;

  // The stimulus alternates between phases that grow the list, mix every action
  // and shrink it again, so that both the full and the empty list are reached.
  typedef enum int {
    PH_FILL,
    PH_MIXED,
    PH_DRAIN
  } phase_kind_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_item;

  // Items still to be offered to the block, in order.
  in_item_t  queued_actions[$];
  // Results the list is owed, oldest first.
  out_item_t owed_results[$];

  // The predicted list: its entries, front first, and how many are held.
  logic signed [31:0] list_store [DEPTH];
  int                 list_count = 0;

  int        cycle_count   = 0;
  int        sent_count    = 0;
  int        checked_count = 0;
  int        failures      = 0;
  int        full_refusals = 0;
  int        missing_hits  = 0;
  int        peak_count    = 0;
  out_item_t oldest_owed;

  positional_list_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Counts and, for the first few, reports every failure of the run.
  function automatic void report_failure(string what);
    failures++;
    if (failures <= REPORT_MAX) begin
      $display("ERROR at cycle %0d: %s", cycle_count, what);
    end
  endfunction

  // Applies one action to the predicted list and returns the result the block must give.
  // Grow actions into a full list are refused; pops and reads that find nothing report
  // a missing entry and a zero value. An insert at index zero or into an empty list goes
  // to the front, and an insert at or past the end, any position above the depth included,
  // appends at the back.
  function automatic out_item_t apply_list_action(in_item_t cmd);
    out_item_t res;
    int        slot;
    int        i;
    res        = '0;
    res.status = STAT_OK;
    case (cmd.action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT: begin
        if (list_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          if (cmd.action == ACT_PUSH_BACK) begin
            slot = list_count;
          end else if (cmd.action == ACT_PUSH_FRONT || cmd.position == 7'd0) begin
            slot = 0;
          end else if (int'(cmd.position) >= list_count) begin
            slot = list_count;
          end else begin
            slot = int'(cmd.position);
          end
          for (i = list_count; i > slot; i--) begin
            list_store[i] = list_store[i - 1];
          end
          list_store[slot] = cmd.item_value;
          list_count++;
        end
      end
      ACT_POP_BACK: begin
        if (list_count == 0) begin
          res.status = STAT_MISSING;
        end else begin
          list_count--;
        end
      end
      ACT_POP_FRONT: begin
        if (list_count == 0) begin
          res.status = STAT_MISSING;
        end else begin
          for (i = 1; i < list_count; i++) begin
            list_store[i - 1] = list_store[i];
          end
          list_count--;
        end
      end
      ACT_RD_FRONT: begin
        if (list_count == 0) begin
          res.status = STAT_MISSING;
        end else begin
          res.read_value = list_store[0];
        end
      end
      ACT_RD_BACK: begin
        if (list_count == 0) begin
          res.status = STAT_MISSING;
        end else begin
          res.read_value = list_store[list_count - 1];
        end
      end
      default: begin
        if (int'(cmd.position) < list_count && int'(cmd.position) < DEPTH) begin
          res.read_value = list_store[AW'(cmd.position)];
        end else begin
          res.status = STAT_MISSING;
        end
      end
    endcase
    if (res.status == STAT_FULL) begin
      full_refusals++;
    end
    if (res.status == STAT_MISSING) begin
      missing_hits++;
    end
    if (list_count > peak_count) begin
      peak_count = list_count;
    end
    res.entry_count = 7'(list_count);
    return res;
  endfunction

  // Decides whether the sender leaves the next cycle empty. A stretch in the middle of
  // the run offers items back to back so that the block sees an unbroken command stream.
  function automatic bit take_gap();
    if (sent_count >= 450 && sent_count < 650) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 21;
  endfunction

  function automatic void add_action(action_t act, logic signed [31:0] value,
                                     logic [6:0] pos);
    in_item_t cmd;
    cmd.action     = act;
    cmd.item_value = value;
    cmd.position   = pos;
    queued_actions.push_back(cmd);
  endfunction

  // Builds one random action whose mix depends on the phase of the run.
  function automatic void add_random_action(phase_kind_t kind);
    action_t            act;
    logic signed [31:0] value;
    logic [6:0]         pos;
    int                 pick;
    pick = $urandom_range(0, 99);
    case (kind)
      PH_FILL: begin
        if (pick < 40) begin
          act = ACT_PUSH_BACK;
        end else if (pick < 60) begin
          act = ACT_PUSH_FRONT;
        end else if (pick < 85) begin
          act = ACT_INSERT;
        end else if (pick < 90) begin
          act = (pick < 88) ? ACT_POP_BACK : ACT_POP_FRONT;
        end else begin
          act = action_t'(3'($urandom_range(4, 6)));
        end
      end
      PH_DRAIN: begin
        if (pick < 40) begin
          act = ACT_POP_BACK;
        end else if (pick < 85) begin
          act = ACT_POP_FRONT;
        end else if (pick < 90) begin
          act = (pick < 88) ? ACT_INSERT : ACT_PUSH_BACK;
        end else begin
          act = action_t'(3'($urandom_range(4, 6)));
        end
      end
      default: begin
        act = action_t'(3'($urandom_range(0, 7)));
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      value = 32'sh7FFF_FFFF;
    end else if (pick < 6) begin
      value = 32'sh8000_0000;
    end else if (pick < 8) begin
      value = '0;
    end else if (pick < 10) begin
      value = -32'sd1;
    end else begin
      value = $urandom;
    end
    // Positions are mostly inside the list's range; some are tiny and some use all
    // seven bits, which exercises the indices beyond the depth.
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      pos = 7'($urandom_range(0, DEPTH));
    end else if (pick < 85) begin
      pos = 7'($urandom_range(0, 3));
    end else begin
      pos = 7'($urandom_range(0, 127));
    end
    add_action(act, value, pos);
  endfunction

  // Driver. An item transfers at a rising edge with start high and busy low. The item
  // on the port is held until it transfers; after a transfer the next one may follow at
  // once, so start stays high across back-to-back items without being lowered.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        owed_results.push_back(apply_list_action(in_item));
        sent_count++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (queued_actions.size() > 0 && !take_gap()) begin
        in_item <= queued_actions[0];
        queued_actions.delete(0);
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. A result is shown for exactly one cycle and transfers at the edge that ends
  // that cycle; it is compared field by field with the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (owed_results.size() == 0) begin
        report_failure($sformatf("result with nothing owed: value %0d status %0d count %0d",
                                 out_item.read_value, out_item.status, out_item.entry_count));
      end else begin
        oldest_owed = owed_results[0];
        owed_results.delete(0);
        checked_count++;
        if (out_item.read_value !== oldest_owed.read_value ||
            out_item.status !== oldest_owed.status ||
            out_item.entry_count !== oldest_owed.entry_count) begin
          report_failure($sformatf(
              "result %0d: expected value %0d status %0d count %0d, got %0d %0d %0d",
              checked_count, oldest_owed.read_value, oldest_owed.status,
              oldest_owed.entry_count, out_item.read_value, out_item.status,
              out_item.entry_count));
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results still owed", cycle_count,
               owed_results.size());
      $display("tb_positional_list_engine failed");
      $finish;
    end
  end

  initial begin
    // Directed opening: every empty-list case, the value extremes, inserts at the front,
    // in the middle and past the end, and reads at, past and far beyond the last entry.
    add_action(ACT_POP_BACK, 32'sd11, 7'd0);
    add_action(ACT_POP_FRONT, 32'sd12, 7'd0);
    add_action(ACT_RD_FRONT, 32'sd13, 7'd0);
    add_action(ACT_RD_BACK, 32'sd14, 7'd0);
    add_action(ACT_RD_INDEX, 32'sd15, 7'd0);
    add_action(ACT_INSERT, 32'sh7FFF_FFFF, 7'd5);
    add_action(ACT_PUSH_BACK, 32'sh8000_0000, 7'd127);
    add_action(ACT_PUSH_FRONT, -32'sd1, 7'd0);
    add_action(ACT_INSERT, 32'sd0, 7'd0);
    add_action(ACT_INSERT, 32'sh1234_5678, 7'd2);
    add_action(ACT_INSERT, 32'sh55AA_55AA, 7'd127);
    add_action(ACT_INSERT, 32'shAA55_AA55, 7'd64);
    add_action(ACT_RD_INDEX, 32'sd0, 7'd127);
    add_action(ACT_RD_INDEX, 32'sd0, 7'd64);
    add_action(ACT_RD_INDEX, 32'sd0, 7'd7);
    add_action(ACT_RD_INDEX, 32'sd0, 7'd6);
    add_action(ACT_RD_FRONT, 32'sd0, 7'd0);
    add_action(ACT_RD_BACK, 32'sd0, 7'd0);
    add_action(ACT_RD_INDEX, 32'sd0, 7'd2);
    add_action(ACT_POP_BACK, 32'sd0, 7'd0);
    add_action(ACT_POP_FRONT, 32'sd0, 7'd0);
    add_action(ACT_INSERT, 32'sh0BAD_F00D, 7'd1);
    add_action(ACT_RD_INDEX, 32'sd0, 7'd1);

    // Random part in phases of fill, mix and drain, which reaches the full list and
    // its refusals as well as runs of pops on an empty list.
    while (queued_actions.size() < ITEM_TOTAL) begin
      case ((queued_actions.size() / PHASE_LEN) % 4)
        0:       add_random_action(PH_FILL);
        2:       add_random_action(PH_DRAIN);
        default: add_random_action(PH_MIXED);
      endcase
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_actions.size() > 0 || start || owed_results.size() > 0) begin
      @(posedge clk);
    end
    // Let a stray late result show up before the verdict.
    repeat (WORST_LATENCY) @(posedge clk);
    if (owed_results.size() > 0) begin
      report_failure($sformatf("%0d results never arrived", owed_results.size()));
    end

    $display("Sent %0d list actions and checked %0d results in %0d cycles.", sent_count,
             checked_count, cycle_count);
    $display("Peak fill %0d of %0d, %0d full refusals, %0d empty or missing lookups.",
             peak_count, DEPTH, full_refusals, missing_hits);
    if (failures == 0) begin
      $display("tb_positional_list_engine passed");
    end else begin
      $display("tb_positional_list_engine failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ple_pkg.sv
hdl/ple_ctrl.sv
hdl/ple_dpath.sv
hdl/positional_list_engine.sv
tb/sv/tb_positional_list_engine.sv
